/* rtl/core/chmd_pkg.sv */
`timescale 1ns / 1ps

package chmd_pkg;

    localparam int PERIOD_W = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd195;

    typedef logic [PERIOD_W-1:0] t_period;

endpackage

/* rtl/core/chorus_modulated_delay.sv */
`timescale 1ns / 1ps
// Channel   Direction  Signals
// input     in         i_in_valid / o_in_ready, i_sample_in
// output    out        o_out_valid / i_out_ready, o_mix_out
// config    in         i_cfg_valid / o_cfg_ready, i_cfg_sweep_period
//
// One sample per cycle sustained while i_out_ready stays high; o_out_valid rises once the
// input transaction has passed the read stage (memory read at the accepting edge) and the output sum register.
// Reset clears the write pointer, sweep state and a fill flag; unwritten memory reads
// as zero, so no clearing pass is needed. The memory read is enabled only by an input
// transaction; a stall on the output holds the read stage, and o_in_ready drops while
// both the read stage and the output register are full and i_out_ready is low.

module chorus_modulated_delay
    import chmd_pkg::*;
#(
    parameter int DELAY_DEPTH  = 340,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH:0]   o_mix_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  t_period                        i_cfg_sweep_period
);

    localparam int PTR_W = $clog2(DELAY_DEPTH);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DELAY_DEPTH - 1);

    logic signed [SAMPLE_WIDTH-1:0] mem [DELAY_DEPTH];

    logic [PTR_W-1:0]               r_wr_ptr;
    logic                           r_wrapped;
    logic [PTR_W-1:0]               cur_delay;
    logic [PTR_W-1:0]               rd_ptr;
    logic                           accept;
    logic                           advance;

    logic                           r_s1_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_s1_x;
    logic                           r_s1_bypass;
    logic                           r_s1_filled;
    logic signed [SAMPLE_WIDTH-1:0] r_rd_data;
    logic signed [SAMPLE_WIDTH-1:0] delayed;
    logic signed [SAMPLE_WIDTH:0]   sum;

    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH:0]   r_out_data;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || advance;
    assign accept      = i_in_valid && o_in_ready;

    chmd_sweep #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_sweep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_period   (i_cfg_sweep_period),
        .i_step         (accept),
        .o_delay_length (cur_delay)
    );

    // read index wraps by adding the depth
    always_comb begin
        if (r_wr_ptr >= cur_delay) begin
            rd_ptr = r_wr_ptr - cur_delay;
        end else begin
            rd_ptr = r_wr_ptr + (LAST - cur_delay) + PTR_W'(1);
        end
    end

    // zero delay length reads the entry being written: take the input directly
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_wr_ptr] <= i_sample_in;
            r_rd_data     <= mem[rd_ptr];
            r_s1_x        <= i_sample_in;
            r_s1_bypass   <= (cur_delay == '0);
            r_s1_filled   <= r_wrapped || (rd_ptr < r_wr_ptr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_wrapped <= 1'b0;
        end else if (accept) begin
            if (r_wr_ptr == LAST) begin
                r_wr_ptr  <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
        end
    end

    always_comb begin
        if (r_s1_bypass) begin
            delayed = r_s1_x;
        end else if (r_s1_filled) begin
            delayed = r_rd_data;
        end else begin
            delayed = '0;
        end
        sum = (SAMPLE_WIDTH + 1)'(r_s1_x) + (SAMPLE_WIDTH + 1)'(delayed >>> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_data <= sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mix_out   = r_out_data;

endmodule

/* rtl/core/chmd_sweep.sv */
`timescale 1ns / 1ps

module chmd_sweep
    import chmd_pkg::*;
#(
    parameter int DELAY_DEPTH = 340,
    localparam int LEN_W = $clog2(DELAY_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  t_period          i_cfg_period,
    input  logic             i_step,
    output logic [LEN_W-1:0] o_delay_length
);

    localparam logic [LEN_W-1:0] LAST = LEN_W'(DELAY_DEPTH - 1);
    localparam logic [LEN_W-1:0] ONE  = LEN_W'(1);

    t_period          r_period;
    t_period          r_tick;
    t_period          n_tick;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_down;
    logic             n_down;

    always_comb begin
        n_len  = r_len;
        n_down = r_down;
        if (r_tick == r_period) begin
            n_tick = t_period'(1);
            if (r_down) begin
                if (r_len != '0) begin
                    n_len = r_len - ONE;
                end
            end else begin
                if (r_len < LAST) begin
                    n_len = r_len + ONE;
                end
            end
        end else begin
            n_tick = r_tick + t_period'(1);
        end
        if (n_len >= LAST) begin
            n_down = 1'b1;
        end
        if (n_len <= ONE) begin
            n_down = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_tick   <= '0;
            r_len    <= '0;
            r_down   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_period;
            end
            if (i_step) begin
                r_tick <= n_tick;
                r_len  <= n_len;
                r_down <= n_down;
            end
        end
    end

    assign o_delay_length = r_len;

endmodule

/* tb/tb_chorus_modulated_delay.sv */
`timescale 1ns / 1ps

module tb_chorus_modulated_delay;
    import chmd_pkg::*;

    localparam int DEPTH      = 340;
    localparam int LAST       = DEPTH - 1;
    localparam int IDLE_PCT   = 6;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic signed [15:0]   i_sample_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic signed [16:0]   o_mix_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_period              i_cfg_sweep_period = '0;

    chorus_modulated_delay #(
        .DELAY_DEPTH  (DEPTH),
        .SAMPLE_WIDTH (16)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_sample_in        (i_sample_in),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_mix_out          (o_mix_out),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_sweep_period (i_cfg_sweep_period)
    );

    always #10 i_clk = ~i_clk;

    // Mirror of the block state
    logic signed [15:0] line_m [DEPTH];
    int unsigned        wr_ptr_m;
    int unsigned        dly_len_m;
    logic               sweep_dn_m;
    t_period            tick_m;
    t_period            period_m;

    logic signed [16:0] expected_mix_q [$];
    int                 mismatches = 0;
    bit                 no_idle = 1'b0;
    int                 quiet_cycles = 0;

    task automatic chorus_predict(input logic signed [15:0] x);
        int unsigned        rd;
        logic signed [16:0] half_dly;
        logic signed [16:0] x_ext;
        rd = (wr_ptr_m >= dly_len_m) ? wr_ptr_m - dly_len_m : wr_ptr_m + DEPTH - dly_len_m;
        line_m[wr_ptr_m] = x;
        wr_ptr_m = (wr_ptr_m == LAST) ? 0 : wr_ptr_m + 1;
        half_dly = 17'(line_m[rd]);
        half_dly = half_dly >>> 1;
        x_ext = 17'(x);
        if (tick_m == period_m) begin
            if (sweep_dn_m) begin
                if (dly_len_m > 0) dly_len_m--;
            end else begin
                if (dly_len_m < LAST) dly_len_m++;
            end
            tick_m = '0;
        end
        tick_m = tick_m + 1'b1;
        if (dly_len_m >= LAST) sweep_dn_m = 1'b1;
        if (dly_len_m <= 1) sweep_dn_m = 1'b0;
        expected_mix_q.push_back(half_dly + x_ext);
    endtask

    task automatic send_sample(input logic signed [15:0] s);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_in_ready);
        chorus_predict(s);
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_mix_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_period(input t_period p);
        wait_drain();
        @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_sweep_period <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_m = p;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Reset value of the period; zero delay reads back the sample just written
    task automatic test_sample_extremes();
        logic signed [15:0] vals [14];
        vals = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001, 16'sh7FFF,
                 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh5555, 16'shAAAA, 16'sh7FFE,
                 16'sh8001, 16'sh0000};
        foreach (vals[i]) send_sample(vals[i]);
        stop_input();
    endtask

    // Max period, then drop to zero after the counter has already passed it
    task automatic test_period_change();
        write_period(16'hFFFF);
        for (int i = 0; i < 6; i++) send_sample(rand_sample());
        stop_input();
        write_period(16'h0000);
        for (int i = 0; i < 5; i++) send_sample(rand_sample());
        stop_input();
    endtask

    // Period zero with the counter past it: no step; sent with no idling on either side
    task automatic test_long_stretch();
        no_idle = 1'b1;
        for (int i = 0; i < 200; i++) send_sample(16'($urandom));
        stop_input();
        no_idle = 1'b0;
    endtask

    // Fast sweep to hit both turn points of the triangle
    task automatic test_sweep_turns();
        // match the period to the running count so the counter restarts
        write_period(tick_m);
        send_sample(rand_sample());
        stop_input();
        write_period(16'h0001);
        for (int i = 0; i < 1400; i++) begin
            send_sample(rand_sample());
            if (i == 700) begin
                // hold off until the output side has caught up
                stop_input();
                wait_drain();
            end
        end
        stop_input();
    endtask

    task automatic test_random_periods();
        t_period p;
        int      n;
        for (int chunk = 0; chunk < 5; chunk++) begin
            case ($urandom_range(0, 5))
                0: p = 16'h0000;
                1: p = 16'($urandom_range(1, 3));
                2: p = 16'($urandom_range(4, 40));
                3: p = PERIOD_RESET;
                4: p = 16'hFFFF;
                default: p = 16'($urandom);
            endcase
            write_period(p);
            n = $urandom_range(80, 160);
            for (int i = 0; i < n; i++) send_sample(rand_sample());
            stop_input();
        end
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        logic signed [16:0] exp_mix;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_mix_q.size() == 0) begin
                $display("%0t: unexpected mix_out, expected none, got %0d",
                         $realtime, o_mix_out);
                mismatches++;
            end else begin
                exp_mix = expected_mix_q.pop_front();
                if (o_mix_out !== exp_mix) begin
                    $display("%0t: mix_out expected %0d, got %0d",
                             $realtime, exp_mix, o_mix_out);
                    mismatches++;
                end
            end
        end
    end

    // Stall watchdog: no transaction on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (line_m[i]) line_m[i] = '0;
        wr_ptr_m   = 0;
        dly_len_m  = 0;
        sweep_dn_m = 1'b0;
        tick_m     = '0;
        period_m   = PERIOD_RESET;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sample_extremes();
        test_period_change();
        test_long_stretch();
        test_sweep_turns();
        test_random_periods();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/chmd_pkg.sv
rtl/core/chmd_sweep.sv
rtl/core/chorus_modulated_delay.sv
tb/tb_chorus_modulated_delay.sv
